// File: rtl/msq_pkg.sv
// Package for the marching squares cell segment block.
// Widths, segment types and helpers shared by the interfaces and all modules.
// Depends on nothing.
package msq_pkg;

   localparam int FRAC_BITS   = 12;
   localparam int FRAC_W      = FRAC_BITS + 1;
   localparam int IDX_W       = 6;
   localparam int SAMPLE_W    = 16;
   localparam int DIFF_W      = 16;
   localparam int COORD_W     = 18;
   localparam int DIV_STAGES  = 4;
   localparam int DIV_BITS    = FRAC_BITS / DIV_STAGES;
   localparam int PIPE_STAGES = DIV_STAGES + 2;
   localparam int NUM_EDGES   = 4;
   localparam int ADDR_W      = 3;
   localparam int DATA_W      = 32;

   localparam logic [ADDR_W-1:0] REG_ISO_LEVEL = ADDR_W'(0);
   localparam logic [FRAC_W-1:0] FRAC_ONE      = FRAC_W'(1) << FRAC_BITS;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [3:0]         code_type;

   typedef struct packed {
      coord_type j1;
      coord_type i1;
      coord_type j2;
      coord_type i2;
   } seg_type;

   typedef enum logic [1:0] {PT_A, PT_B, PT_C, PT_D} point_type;

   typedef struct packed {
      logic [1:0] nseg;
      point_type  s0_from;
      point_type  s0_to;
      point_type  s1_from;
      point_type  s1_to;
   } route_type;

   function automatic logic [DIFF_W-1:0] abs_diff(logic signed [SAMPLE_W-1:0] x,
                                                  logic signed [SAMPLE_W-1:0] y);
      logic signed [SAMPLE_W:0] d;
      logic        [SAMPLE_W:0] n;
      d = {x[SAMPLE_W-1], x} - {y[SAMPLE_W-1], y};
      n = (~d) + (SAMPLE_W+1)'(1);
      return d[SAMPLE_W] ? n[DIFF_W-1:0] : d[DIFF_W-1:0];
   endfunction

   function automatic coord_type make_coord(logic [IDX_W-1:0] idx, logic [FRAC_W-1:0] frac);
      logic [COORD_W:0] sum;
      sum = (COORD_W+1)'({idx, {FRAC_BITS{1'b0}}}) + (COORD_W+1)'(frac);
      return sum[COORD_W] ? {COORD_W{1'b1}} : sum[COORD_W-1:0];
   endfunction

   // segment table indexed by the corner case code
   function automatic route_type route_of(code_type code);
      route_type r;
      r = '{nseg: 2'd0, s0_from: PT_A, s0_to: PT_A, s1_from: PT_C, s1_to: PT_D};
      unique case (code)
         4'd1, 4'd14: r = '{2'd1, PT_B, PT_A, PT_C, PT_D};
         4'd2, 4'd13: r = '{2'd1, PT_A, PT_C, PT_C, PT_D};
         4'd3, 4'd12: r = '{2'd1, PT_B, PT_C, PT_C, PT_D};
         4'd4, 4'd11: r = '{2'd1, PT_C, PT_D, PT_C, PT_D};
         4'd6, 4'd9:  r = '{2'd1, PT_A, PT_D, PT_C, PT_D};
         4'd7, 4'd8:  r = '{2'd1, PT_B, PT_D, PT_C, PT_D};
         4'd5, 4'd10: r = '{2'd2, PT_A, PT_B, PT_C, PT_D};
         default:     r = '{2'd0, PT_A, PT_A, PT_C, PT_D};
      endcase
      return r;
   endfunction

endpackage

// File: rtl/msq_if.sv
// Channel interfaces for cell words in and segment words out.
// Depends on msq_pkg.
interface msq_req_if import msq_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [IDX_W-1:0]           cell_i;
   logic [IDX_W-1:0]           cell_j;
   logic signed [SAMPLE_W-1:0] corner_base;
   logic signed [SAMPLE_W-1:0] corner_next_j;
   logic signed [SAMPLE_W-1:0] corner_diag;
   logic signed [SAMPLE_W-1:0] corner_next_i;

   modport source(output valid, cell_i, cell_j, corner_base, corner_next_j,
                  corner_diag, corner_next_i, input ready);
   modport sink(input valid, cell_i, cell_j, corner_base, corner_next_j,
                corner_diag, corner_next_i, output ready);
endinterface

interface msq_rsp_if import msq_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type first_j_coord;
   coord_type first_i_coord;
   coord_type second_j_coord;
   coord_type second_i_coord;
   logic      last_segment;

   modport source(output valid, first_j_coord, first_i_coord, second_j_coord,
                  second_i_coord, last_segment, input ready);
   modport sink(input valid, first_j_coord, first_i_coord, second_j_coord,
                second_i_coord, last_segment, output ready);
endinterface

// File: rtl/msq_edge_div.sv
// Pipelined edge fraction divider: |level-a| / |b-a| with saturation at one.
// Several quotient bits per stage; stage loads follow the caller's enables.
// Depends on msq_pkg.
module msq_edge_div import msq_pkg::*; (
   input  logic                    clock,
   input  logic [DIV_STAGES-1:0]   en,
   input  logic [DIFF_W-1:0]       num,
   input  logic [DIFF_W-1:0]       den,
   output logic [FRAC_W-1:0]       frac
);

   logic [DIFF_W-1:0]    rem_ff [DIV_STAGES];
   logic [DIFF_W-1:0]    den_ff [DIV_STAGES];
   logic [FRAC_BITS-1:0] quo_ff [DIV_STAGES];
   logic                 zero_ff[DIV_STAGES];
   logic                 sat_ff [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic [DIFF_W-1:0]    rem_in;
      logic [FRAC_BITS-1:0] quo_in;
      logic [DIFF_W-1:0]    d_src;
      logic                 zero_in;
      logic                 sat_in;

      always_comb begin
         logic [DIFF_W:0] r2;
         if (s == 0) begin
            rem_in  = num;
            quo_in  = '0;
            d_src   = den;
            zero_in = (den == '0);
            sat_in  = (num >= den);
         end else begin
            rem_in  = rem_ff[s-1];
            quo_in  = quo_ff[s-1];
            d_src   = den_ff[s-1];
            zero_in = zero_ff[s-1];
            sat_in  = sat_ff[s-1];
         end
         for (int b = 0; b < DIV_BITS; b++) begin
            r2 = {rem_in, 1'b0};
            quo_in = {quo_in[FRAC_BITS-2:0], (r2 >= {1'b0, d_src})};
            if (r2 >= {1'b0, d_src}) begin
               r2 = r2 - {1'b0, d_src};
            end
            rem_in = r2[DIFF_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (en[s]) begin
            rem_ff[s]  <= rem_in;
            quo_ff[s]  <= quo_in;
            den_ff[s]  <= d_src;
            zero_ff[s] <= zero_in;
            sat_ff[s]  <= sat_in;
         end
      end
   end

   always_comb begin
      priority if (zero_ff[DIV_STAGES-1]) begin
         frac = '0;
      end else if (sat_ff[DIV_STAGES-1]) begin
         frac = FRAC_ONE;
      end else begin
         frac = {1'b0, quo_ff[DIV_STAGES-1]};
      end
   end

endmodule

// File: rtl/marching_squares_cell_segments.sv
// Top level of the marching squares cell segment block.
// Depends on msq_pkg, msq_if and msq_edge_div.
//
//  channel   dir   word                                  handshake
//  req_chan  in    cell indices + four corner samples    valid/ready
//  rsp_chan  out   one segment, two endpoints + last     valid/ready
//  csr       in    iso_level at byte 0                   APB, pready high
//
// Six register stages lie between an accepted cell and its first segment:
// one edge stage, four divider stages of three quotient bits each, one
// output stage. One cell per cycle enters unless a stall holds it; saddle
// cells hold the output stage until their second segment is taken.
// Reset clears valid bits and iso_level; stalls back up stage by stage.
module marching_squares_cell_segments import msq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   msq_req_if.sink           req_chan,
   msq_rsp_if.source         rsp_chan,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   localparam int LAST = PIPE_STAGES - 1;

   logic signed [SAMPLE_W-1:0] level_ff;
   logic [PIPE_STAGES-1:0]     v_ff;
   logic [PIPE_STAGES-1:0]     rdy;
   logic [IDX_W-1:0]           ci_ff  [DIV_STAGES+1];
   logic [IDX_W-1:0]           cj_ff  [DIV_STAGES+1];
   code_type                   code_ff[DIV_STAGES+1];
   logic [DIFF_W-1:0]          num_ff [NUM_EDGES];
   logic [DIFF_W-1:0]          den_ff [NUM_EDGES];
   logic [FRAC_W-1:0]          frac   [NUM_EDGES];
   seg_type                    seg0_ff, seg1_ff, seg0_in, seg1_in;
   logic                       two_ff, idx_ff, two_in;
   logic [1:0]                 nseg;
   code_type                   code_in;
   logic                       rsp_fire;

   // config port
   assign pready = 1'b1;
   assign prdata = DATA_W'(level_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else if (psel && penable && pwrite && paddr == REG_ISO_LEVEL) begin
         level_ff <= pwdata[SAMPLE_W-1:0];
      end
   end

   // stall chain
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;

   always_comb begin
      rdy[LAST] = !v_ff[LAST] || (rsp_chan.ready && (!two_ff || idx_ff));
      for (int k = LAST - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   assign req_chan.ready = rdy[0];

   // edge stage
   always_comb begin
      code_in = {req_chan.corner_next_i > level_ff, req_chan.corner_diag > level_ff,
                 req_chan.corner_next_j > level_ff, req_chan.corner_base > level_ff};
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         ci_ff[0]   <= req_chan.cell_i;
         cj_ff[0]   <= req_chan.cell_j;
         code_ff[0] <= code_in;
         num_ff[0]  <= abs_diff(level_ff, req_chan.corner_base);
         den_ff[0]  <= abs_diff(req_chan.corner_next_j, req_chan.corner_base);
         num_ff[1]  <= abs_diff(level_ff, req_chan.corner_base);
         den_ff[1]  <= abs_diff(req_chan.corner_next_i, req_chan.corner_base);
         num_ff[2]  <= abs_diff(level_ff, req_chan.corner_next_j);
         den_ff[2]  <= abs_diff(req_chan.corner_diag, req_chan.corner_next_j);
         num_ff[3]  <= abs_diff(level_ff, req_chan.corner_next_i);
         den_ff[3]  <= abs_diff(req_chan.corner_diag, req_chan.corner_next_i);
      end
   end

   // divider stages
   for (genvar e = 0; e < NUM_EDGES; e++) begin : g_edge
      msq_edge_div u_div (
         .clock (clock),
         .en    (rdy[DIV_STAGES:1]),
         .num   (num_ff[e]),
         .den   (den_ff[e]),
         .frac  (frac[e])
      );
   end

   for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_side
      always_ff @(posedge clock) begin
         if (rdy[s]) begin
            ci_ff[s]   <= ci_ff[s-1];
            cj_ff[s]   <= cj_ff[s-1];
            code_ff[s] <= code_ff[s-1];
         end
      end
   end

   // segment build
   always_comb begin
      coord_type pj[4];
      coord_type pi[4];
      route_type rt;
      pj[PT_A] = make_coord(cj_ff[DIV_STAGES], frac[0]);
      pi[PT_A] = make_coord(ci_ff[DIV_STAGES], '0);
      pj[PT_B] = make_coord(cj_ff[DIV_STAGES], '0);
      pi[PT_B] = make_coord(ci_ff[DIV_STAGES], frac[1]);
      pj[PT_C] = make_coord(cj_ff[DIV_STAGES], FRAC_ONE);
      pi[PT_C] = make_coord(ci_ff[DIV_STAGES], frac[2]);
      pj[PT_D] = make_coord(cj_ff[DIV_STAGES], frac[3]);
      pi[PT_D] = make_coord(ci_ff[DIV_STAGES], FRAC_ONE);
      rt       = route_of(code_ff[DIV_STAGES]);
      nseg     = rt.nseg;
      two_in   = (rt.nseg == 2'd2);
      seg0_in  = '{pj[rt.s0_from], pi[rt.s0_from], pj[rt.s0_to], pi[rt.s0_to]};
      seg1_in  = '{pj[rt.s1_from], pi[rt.s1_from], pj[rt.s1_to], pi[rt.s1_to]};
   end

   always_ff @(posedge clock) begin
      if (rdy[LAST]) begin
         seg0_ff <= seg0_in;
         seg1_ff <= seg1_in;
         two_ff  <= two_in;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff   <= '0;
         idx_ff <= 1'b0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= req_chan.valid;
         end
         for (int k = 1; k < LAST; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
         if (rdy[LAST]) begin
            v_ff[LAST] <= v_ff[LAST-1] && (nseg != 2'd0);
            idx_ff     <= 1'b0;
         end else if (rsp_fire) begin
            idx_ff <= 1'b1;
         end
      end
   end

   // output
   assign rsp_chan.valid          = v_ff[LAST];
   assign rsp_chan.first_j_coord  = idx_ff ? seg1_ff.j1 : seg0_ff.j1;
   assign rsp_chan.first_i_coord  = idx_ff ? seg1_ff.i1 : seg0_ff.i1;
   assign rsp_chan.second_j_coord = idx_ff ? seg1_ff.j2 : seg0_ff.j2;
   assign rsp_chan.second_i_coord = idx_ff ? seg1_ff.i2 : seg0_ff.i2;
   assign rsp_chan.last_segment   = !two_ff || idx_ff;

endmodule

// File: rtl/msq_checker.sv
// Port checker for the marching squares cell segment block, with its bind.
// Depends on msq_pkg.
module msq_checker import msq_pkg::*; (
   input logic      clock,
   input logic      reset,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input logic      last_segment,
   input coord_type first_i_coord,
   input coord_type second_j_coord
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("segment word dropped while stalled");

   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !last_segment |=> rsp_valid)
      else $error("second saddle segment missing");

   a_saddle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !last_segment |->
         first_i_coord[FRAC_BITS-1:0] == '0 && second_j_coord[FRAC_BITS-1:0] == '0)
      else $error("first saddle segment off its edges");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("segment word shown after reset");

endmodule

bind marching_squares_cell_segments msq_checker u_msq_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .last_segment   (rsp_chan.last_segment),
   .first_i_coord  (rsp_chan.first_i_coord),
   .second_j_coord (rsp_chan.second_j_coord)
);
